// File: hw/rtl/i2c_register_read_master_unit_defines.svh
// Assertion macros shared by the register read master RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef I2C_REGISTER_READ_MASTER_UNIT_DEFINES_SVH
`define I2C_REGISTER_READ_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2C_RRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2c_rrm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2C_RRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2c_rrm: next-cycle check failed");

`endif

// File: hw/rtl/i2c_rrm_pkg.sv
// Shared constants and types of the register read master.
// Used by i2c_rrm_step_decode and the top level; depends on nothing.
`default_nettype none

package i2c_rrm_pkg;

    localparam int READ_BYTES   = 3;
    localparam int SEG_PREFIX   = 92;
    localparam int SEG_PER_BYTE = 28;
    localparam int TOTAL_OPS    = SEG_PREFIX + SEG_PER_BYTE * READ_BYTES + 3;
    localparam int STEP_W       = $clog2(TOTAL_OPS);
    localparam int IDX_W        = (READ_BYTES > 1) ? $clog2(READ_BYTES) : 1;

    localparam int ADDR_W       = 7;
    localparam int BYTE_W       = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_INDEX = 1'b1;

    // One decoded pin operation
    typedef struct packed {
        logic             scl_we;
        logic             scl_val;
        logic             sda_we;
        logic             sda_val;
        logic             shift_clr;
        logic             shift_smp;
        logic             store;
        logic [IDX_W-1:0] store_idx;
    } op_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2c_rrm_step_decode.sv
// Decodes the step counter into one pin operation of the register read.
// Depends on i2c_rrm_pkg.
`default_nettype none

module i2c_rrm_step_decode (
    input  wire logic [i2c_rrm_pkg::STEP_W-1:0] step,
    input  wire logic [i2c_rrm_pkg::ADDR_W-1:0] device_address,
    input  wire logic [i2c_rrm_pkg::BYTE_W-1:0] register_index,
    output i2c_rrm_pkg::op_t                    op
);

    localparam int STEP_W = i2c_rrm_pkg::STEP_W;

    // Split an offset below 24 into bit number and phase (offset = 3*bit + phase)
    function automatic logic [4:0] div3(input logic [4:0] o);
        logic [2:0] b;
        logic [4:0] rem;
        b = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (o >= 5'(3 * i)) begin
                b = 3'(i);
            end
        end
        rem = o - ({2'b00, b} + {1'b0, b, 1'b0});
        return {b, rem[1:0]};
    endfunction

    function automatic i2c_rrm_pkg::op_t op_start(input logic [1:0] o);
        i2c_rrm_pkg::op_t r;
        r = '0;
        case (o)
            2'd0: begin r.sda_we = 1'b1; r.sda_val = 1'b1; end
            2'd1: begin r.scl_we = 1'b1; r.scl_val = 1'b1; end
            2'd2: begin r.sda_we = 1'b1; r.sda_val = 1'b0; end
            default: begin r.scl_we = 1'b1; r.scl_val = 1'b0; end
        endcase
        return r;
    endfunction

    function automatic i2c_rrm_pkg::op_t op_send(input logic [4:0] o,
                                                 input logic [7:0] b);
        i2c_rrm_pkg::op_t r;
        logic [4:0]       bp;
        r  = '0;
        bp = div3(o);
        case (bp[1:0])
            2'd0: begin r.sda_we = 1'b1; r.sda_val = b[~bp[4:2]]; end
            2'd1: begin r.scl_we = 1'b1; r.scl_val = 1'b1; end
            default: begin r.scl_we = 1'b1; r.scl_val = 1'b0; end
        endcase
        return r;
    endfunction

    // Slave acknowledge slot: the sampled level is dropped
    function automatic i2c_rrm_pkg::op_t op_ack(input logic [1:0] o);
        i2c_rrm_pkg::op_t r;
        r = '0;
        case (o)
            2'd0: begin r.sda_we = 1'b1; r.sda_val = 1'b1; end
            2'd1: begin r.scl_we = 1'b1; r.scl_val = 1'b1; end
            2'd3: begin r.scl_we = 1'b1; r.scl_val = 1'b0; end
            default: r = '0;
        endcase
        return r;
    endfunction

    logic [7:0]                    wr_byte;
    logic [7:0]                    rd_byte;
    logic [STEP_W-1:0]             off;
    logic [STEP_W-1:0]             base;
    logic [i2c_rrm_pkg::IDX_W-1:0] k;
    logic [4:0]                    o5;
    logic [4:0]                    bp;
    logic                          last_byte;

    assign wr_byte = {device_address, 1'b0};
    assign rd_byte = {device_address, 1'b1};

    always_comb begin
        op        = '0;
        off       = '0;
        base      = '0;
        k         = '0;
        o5        = '0;
        bp        = '0;
        last_byte = 1'b0;
        if (step < STEP_W'(4)) begin
            op = op_start(step[1:0]);
        end else if (step < STEP_W'(28)) begin
            off = step - STEP_W'(4);
            op  = op_send(off[4:0], wr_byte);
        end else if (step < STEP_W'(32)) begin
            off = step - STEP_W'(28);
            op  = op_ack(off[1:0]);
        end else if (step < STEP_W'(56)) begin
            off = step - STEP_W'(32);
            op  = op_send(off[4:0], register_index);
        end else if (step < STEP_W'(60)) begin
            off = step - STEP_W'(56);
            op  = op_ack(off[1:0]);
        end else if (step < STEP_W'(64)) begin
            off = step - STEP_W'(60);
            op  = op_start(off[1:0]);
        end else if (step < STEP_W'(88)) begin
            off = step - STEP_W'(64);
            op  = op_send(off[4:0], rd_byte);
        end else if (step < STEP_W'(i2c_rrm_pkg::SEG_PREFIX)) begin
            off = step - STEP_W'(88);
            op  = op_ack(off[1:0]);
        end else if (step < STEP_W'(i2c_rrm_pkg::TOTAL_OPS - 3)) begin
            off = step - STEP_W'(i2c_rrm_pkg::SEG_PREFIX);
            for (int i = 1; i < i2c_rrm_pkg::READ_BYTES; i++) begin
                if (off >= STEP_W'(i2c_rrm_pkg::SEG_PER_BYTE * i)) begin
                    k    = i2c_rrm_pkg::IDX_W'(i);
                    base = STEP_W'(i2c_rrm_pkg::SEG_PER_BYTE * i);
                end
            end
            o5        = 5'(off - base);
            last_byte = (k == i2c_rrm_pkg::IDX_W'(i2c_rrm_pkg::READ_BYTES - 1));
            if (o5 == 5'd0) begin
                op.sda_we    = 1'b1;
                op.sda_val   = 1'b1;
                op.shift_clr = 1'b1;
            end else if (o5 < 5'd25) begin
                bp = div3(o5 - 5'd1);
                case (bp[1:0])
                    2'd0: begin op.scl_we = 1'b1; op.scl_val = 1'b1; end
                    2'd1: op.shift_smp = 1'b1;
                    default: begin
                        op.scl_we    = 1'b1;
                        op.scl_val   = 1'b0;
                        op.store     = (bp[4:2] == 3'd7);
                        op.store_idx = k;
                    end
                endcase
            end else begin
                // Master acknowledge, not acknowledge after the last byte
                op = op_send(o5 - 5'd25, {last_byte, 7'b0});
            end
        end else begin
            off = step - STEP_W'(i2c_rrm_pkg::TOTAL_OPS - 3);
            case (off[1:0])
                2'd0: begin op.sda_we = 1'b1; op.sda_val = 1'b0; end
                2'd1: begin op.scl_we = 1'b1; op.scl_val = 1'b1; end
                default: begin op.sda_we = 1'b1; op.sda_val = 1'b1; end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/i2c_register_read_master_unit.sv
// Top level of the I2C register read master: sequencer state and result register.
// Depends on i2c_rrm_pkg, i2c_rrm_step_decode and the assertion macro header.
//
// Usage:
//   s_ channel: one item per pin tick (s_kind = 0) or a begin request (s_kind = 1),
//   with the sampled data line level on s_sda_in. A begin while busy is ignored.
//   m_ channel: one result item per input item, carrying the line drives, the
//   busy and done flags and the three bytes of the last read.
//   cfg_ port: plain write of the device address (index 0) and register index
//   (index 1); write only while idle.
//   Latency: a result is valid the cycle after its item is accepted.
//   Throughput: one item per cycle while results are taken; the step decode and
//   the line update feed the state registers, which are the result register.
//   A full transaction takes one begin item and 179 tick items.
//   Stall: while a result waits, s_ready stays high only in the cycle the
//   receiver takes it, so a new item is accepted in the same cycle.
//   Reset: lines released high, idle, read bytes zero, registers at 79 and 208.
`default_nettype none
`include "i2c_register_read_master_unit_defines.svh"

module i2c_register_read_master_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [i2c_rrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [i2c_rrm_pkg::BYTE_W-1:0]       cfg_wdata,
    // Input items
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_kind,
    input  wire logic                                 s_sda_in,
    // Result items
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_scl_out,
    output logic                                      m_sda_out,
    output logic                                      m_busy_res,
    output logic                                      m_done_res,
    output logic [i2c_rrm_pkg::BYTE_W-1:0]            m_red,
    output logic [i2c_rrm_pkg::BYTE_W-1:0]            m_green,
    output logic [i2c_rrm_pkg::BYTE_W-1:0]            m_blue
);

    localparam int STEP_W = i2c_rrm_pkg::STEP_W;
    localparam int NB     = i2c_rrm_pkg::READ_BYTES;

    // Configuration registers
    logic [i2c_rrm_pkg::ADDR_W-1:0] dev_addr_reg;
    logic [i2c_rrm_pkg::BYTE_W-1:0] reg_idx_reg;

    // Sequencer state; it also serves as the result register, since it
    // changes only when an item is accepted
    logic [STEP_W-1:0] step_reg,   step_next;
    logic              active_reg, active_next;
    logic [7:0]        shift_reg,  shift_next;
    logic              scl_reg,    scl_next;
    logic              sda_reg,    sda_next;
    logic [7:0]        rb_reg [NB];
    logic [7:0]        rb_next [NB];
    logic              done_reg,   done_next;
    logic              m_valid_reg, m_valid_next;

    logic              accept;
    logic              last_step;
    i2c_rrm_pkg::op_t  op;

    i2c_rrm_step_decode u_decode (
        .step           (step_reg),
        .device_address (dev_addr_reg),
        .register_index (reg_idx_reg),
        .op             (op)
    );

    // Take a new item whenever the result slot is empty or being emptied
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign last_step = (step_reg == STEP_W'(i2c_rrm_pkg::TOTAL_OPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= i2c_rrm_pkg::ADDR_W'(79);
            reg_idx_reg  <= i2c_rrm_pkg::BYTE_W'(208);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                i2c_rrm_pkg::CFG_DEVICE_ADDRESS: dev_addr_reg <= cfg_wdata[6:0];
                i2c_rrm_pkg::CFG_REGISTER_INDEX: reg_idx_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        step_next   = step_reg;
        active_next = active_reg;
        shift_next  = shift_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        rb_next     = rb_reg;
        done_next   = done_reg;
        if (accept) begin
            done_next = 1'b0;
            if (s_kind) begin
                // Begin: arm the sequencer, no pin operation on this item
                if (!active_reg) begin
                    active_next = 1'b1;
                    step_next   = '0;
                end
            end else if (active_reg) begin
                // Tick: perform one pin operation and advance
                if (op.scl_we) begin
                    scl_next = op.scl_val;
                end
                if (op.sda_we) begin
                    sda_next = op.sda_val;
                end
                if (op.shift_clr) begin
                    shift_next = 8'd0;
                end else if (op.shift_smp) begin
                    shift_next = {shift_reg[6:0], s_sda_in};
                end
                if (op.store) begin
                    rb_next[op.store_idx] = shift_reg;
                end
                if (last_step) begin
                    done_next   = 1'b1;
                    active_next = 1'b0;
                    step_next   = '0;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            active_reg  <= 1'b0;
            shift_reg   <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NB; i++) begin
                rb_reg[i] <= 8'd0;
            end
        end else begin
            step_reg    <= step_next;
            active_reg  <= active_next;
            shift_reg   <= shift_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            rb_reg      <= rb_next;
        end
    end

    // Drive the result fields; bytes beyond the read length read as zero
    assign m_valid    = m_valid_reg;
    assign m_scl_out  = scl_reg;
    assign m_sda_out  = sda_reg;
    assign m_busy_res = active_reg;
    assign m_done_res = done_reg;
    assign m_red      = rb_reg[0];

    generate
        if (NB > 1) begin : g_green
            assign m_green = rb_reg[1];
        end else begin : g_no_green
            assign m_green = 8'd0;
        end
        if (NB > 2) begin : g_blue
            assign m_blue = rb_reg[2];
        end else begin : g_no_blue
            assign m_blue = 8'd0;
        end
    endgenerate

    // Checks
    `I2C_RRM_ASSERT_IMP(a_done_not_busy, aclk, aresetn, done_reg, !active_reg)
    `I2C_RRM_ASSERT_IMP(a_idle_step_zero, aclk, aresetn, !active_reg, step_reg == '0)
    `I2C_RRM_ASSERT_IMP(a_step_in_range, aclk, aresetn, active_reg,
        step_reg < STEP_W'(i2c_rrm_pkg::TOTAL_OPS))
    `I2C_RRM_ASSERT_NXT(a_last_tick_done, aclk, aresetn,
        accept && !s_kind && active_reg && last_step, done_reg && m_valid)

endmodule

`default_nettype wire
